[src/lps_pkg.sv]
// lps_pkg: shared types and constants for the line position steering block
// depends on nothing; imported by lps_scan, lps_div and the top level
`default_nettype none

package lps_pkg;

	// fixed field widths
	localparam int SensorCount = 8;
	localparam int PosWidth    = 13;
	localparam int ErrWidth    = 14;
	localparam int AngleWidth  = 8;
	localparam int StepWidth   = 4;
	localparam int CountWidth  = 4;   // 0..8 set sensors
	localparam int IdxSumWidth = 5;   // 0..28 sum of indices
	localparam int DivWidth    = 15;  // index sum * 1000 fits in 15 bits
	localparam int CfgIdxWidth = 2;

	// position and band constants
	localparam logic [DivWidth-1:0] PosUnit  = 15'd1000;
	localparam logic [PosWidth-1:0] PosReset = 13'd3500;
	localparam logic [PosWidth-1:0] PosMax   = 13'd7000;
	localparam logic [2:0]          FullSteps = 3'd7;

	// configuration register indexes
	localparam logic [CfgIdxWidth-1:0] CFG_LINE_IS_WHITE   = 2'd0;
	localparam logic [CfgIdxWidth-1:0] CFG_TARGET_POSITION = 2'd1;
	localparam logic [CfgIdxWidth-1:0] CFG_NEUTRAL_ANGLE   = 2'd2;
	localparam logic [CfgIdxWidth-1:0] CFG_ANGLE_STEP      = 2'd3;

	// configuration reset values
	localparam logic [AngleWidth-1:0] NeutralReset = 8'd93;
	localparam logic [StepWidth-1:0]  StepReset    = 4'd2;

	// control sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DIV,
		ST_FIN
	} state_t;

	// scan unit result
	typedef struct packed {
		logic                   done;
		logic [CountWidth-1:0]  count;
		logic [IdxSumWidth-1:0] idx_sum;
	} scan_res_t;

	// divider result
	typedef struct packed {
		logic                done;
		logic [PosWidth-1:0] quotient;
	} div_res_t;

	// band count from the absolute error, bands of 500
	function automatic logic [2:0] band_count(input logic [PosWidth-1:0] a);
		logic [2:0] k;
		if (a == '0)
			k = 3'd0;
		else if (a < 13'd500)
			k = 3'd1;
		else if (a < 13'd1000)
			k = 3'd2;
		else if (a < 13'd1500)
			k = 3'd3;
		else if (a < 13'd2000)
			k = 3'd4;
		else if (a < 13'd2500)
			k = 3'd5;
		else if (a < 13'd3000)
			k = 3'd6;
		else
			k = FullSteps;
		return k;
	endfunction

endpackage

`default_nettype wire

[src/lps_scan.sv]
// lps_scan: bit-serial sensor scan, one sensor per cycle, leftmost first
// counts the set sensors and sums their indices; uses lps_pkg
`default_nettype none

module lps_scan
	import lps_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	input  wire logic [SensorCount-1:0] bits,
	output scan_res_t                   res
);

	logic [SensorCount-1:0] shift_q;
	logic [2:0]             idx_q;
	logic [CountWidth-1:0]  cnt_q;
	logic [IdxSumWidth-1:0] sum_q;
	logic                   busy_q;
	logic                   done_q;

	// control: busy while sensors remain, one-cycle done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			if (idx_q == 3'd7) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// datapath: shift out msb first, accumulate count and index sum
	always_ff @(posedge clk) begin
		if (start) begin
			shift_q <= bits;
			idx_q   <= '0;
			cnt_q   <= '0;
			sum_q   <= '0;
		end else if (busy_q) begin
			if (shift_q[SensorCount-1]) begin
				cnt_q <= cnt_q + 4'd1;
				sum_q <= sum_q + {2'b00, idx_q};
			end
			shift_q <= {shift_q[SensorCount-2:0], 1'b0};
			idx_q   <= idx_q + 3'd1;
		end
	end

	assign res.done    = done_q;
	assign res.count   = cnt_q;
	assign res.idx_sum = sum_q;

endmodule

`default_nettype wire

[src/lps_div.sv]
// lps_div: restoring divider, one quotient bit per cycle
// divides the weighted index sum by the set-sensor count; uses lps_pkg
`default_nettype none

module lps_div
	import lps_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic [DivWidth-1:0]   dividend,
	input  wire logic [CountWidth-1:0] divisor,
	output div_res_t                   res
);

	logic [DivWidth-1:0]   quo_q;
	logic [CountWidth-1:0] rem_q;
	logic [CountWidth-1:0] dvs_q;
	logic [3:0]            step_q;
	logic                  busy_q;
	logic                  done_q;

	logic [CountWidth:0]   trial;
	logic                  fits;
	logic [CountWidth:0]   diff;

	// one trial subtraction per cycle
	always_comb begin
		trial = {rem_q, quo_q[DivWidth-1]};
		fits  = trial >= {1'b0, dvs_q};
		diff  = trial - {1'b0, dvs_q};
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			if (step_q == 4'(DivWidth - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// datapath: dividend shifts out while quotient bits shift in
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q  <= dividend;
			rem_q  <= '0;
			dvs_q  <= divisor;
			step_q <= '0;
		end else if (busy_q) begin
			rem_q  <= fits ? diff[CountWidth-1:0] : trial[CountWidth-1:0];
			quo_q  <= {quo_q[DivWidth-2:0], fits};
			step_q <= step_q + 4'd1;
		end
	end

	assign res.done     = done_q;
	assign res.quotient = quo_q[PosWidth-1:0];

endmodule

`default_nettype wire

[src/line_position_stepped_steering_core.sv]
// line_position_stepped_steering_core: top level of the line sensor steering block
// holds config registers, sequencer, steering logic and output register
// uses lps_pkg, lps_scan and lps_div
//
// channel | direction | handshake          | payload
// in      | to block  | in_valid/in_stall  | sensor_bits
// out     | from block| out_valid/out_stall| steering_angle, line_position,
//         |           |                    | position_error, line_seen
// cfg     | to block  | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// one word at a time: the result follows the 8-step sensor scan and, when the line is seen,
// the 15-step divider
// a new word is taken while the previous result still waits in the output register
// reset restores the config defaults and a held position of 3500
// out_stall only delays the final load; cfg_ready is always high
`default_nettype none

module line_position_stepped_steering_core
	import lps_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	// input words
	input  wire logic                    in_valid,
	output logic                         in_stall,
	input  wire logic [SensorCount-1:0]  sensor_bits,
	// result words
	output logic                         out_valid,
	input  wire logic                    out_stall,
	output logic [AngleWidth-1:0]        steering_angle,
	output logic [PosWidth-1:0]          line_position,
	output logic signed [ErrWidth-1:0]   position_error,
	output logic                         line_seen,
	// configuration writes
	input  wire logic                    cfg_valid,
	output logic                         cfg_ready,
	input  wire logic [CfgIdxWidth-1:0]  cfg_index,
	input  wire logic [PosWidth-1:0]     cfg_data
);

	// configuration registers
	logic                  white_q;
	logic [PosWidth-1:0]   target_q;
	logic [AngleWidth-1:0] neutral_q;
	logic [StepWidth-1:0]  step_q;

	logic [PosWidth-1:0]   held_q;
	logic                  seen_q;
	state_t                state_q, state_nx;

	logic                  scan_start, div_start, fin_load;
	logic [SensorCount-1:0] line_bits;
	scan_res_t             scan_res;
	div_res_t              div_res;
	logic [DivWidth-1:0]   dividend;

	logic [PosWidth-1:0]   pos;
	logic signed [ErrWidth-1:0] err;
	logic [PosWidth-1:0]   err_abs;
	logic [2:0]            k;
	logic [6:0]            offset;
	logic signed [9:0]     angle;
	logic [AngleWidth-1:0] angle_sat;
	logic                  out_valid_q;

	assign cfg_ready = 1'b1;

	// config write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			white_q   <= 1'b0;
			target_q  <= PosReset;
			neutral_q <= NeutralReset;
			step_q    <= StepReset;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_LINE_IS_WHITE:   white_q   <= cfg_data[0];
				CFG_TARGET_POSITION: target_q  <= cfg_data;
				CFG_NEUTRAL_ANGLE:   neutral_q <= cfg_data[AngleWidth-1:0];
				CFG_ANGLE_STEP:      step_q    <= cfg_data[StepWidth-1:0];
				default: ;
			endcase
		end
	end

	// a 1 always means line seen
	assign line_bits = white_q ? sensor_bits : ~sensor_bits;
	assign dividend  = {{(DivWidth-IdxSumWidth){1'b0}}, scan_res.idx_sum} * PosUnit;

	lps_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (scan_start),
		.bits   (line_bits),
		.res    (scan_res)
	);

	lps_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.divisor  (scan_res.count),
		.res      (div_res)
	);

	// sequencer next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: if (in_valid) state_nx = ST_SCAN;
			ST_SCAN: begin
				if (scan_res.done)
					state_nx = (scan_res.count != '0) ? ST_DIV : ST_FIN;
			end
			ST_DIV: if (div_res.done) state_nx = ST_FIN;
			ST_FIN: if (!out_valid_q || !out_stall) state_nx = ST_IDLE;
			default: state_nx = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_stall   = (state_q != ST_IDLE);
		scan_start = (state_q == ST_IDLE) && in_valid;
		div_start  = (state_q == ST_SCAN) && scan_res.done && (scan_res.count != '0);
		fin_load   = (state_q == ST_FIN) && (!out_valid_q || !out_stall);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			seen_q  <= 1'b0;
			held_q  <= PosReset;
		end else begin
			state_q <= state_nx;
			if (state_q == ST_SCAN && scan_res.done)
				seen_q <= (scan_res.count != '0);
			if (fin_load && seen_q)
				held_q <= div_res.quotient;
		end
	end

	// steering: position, error, band and saturated angle
	always_comb begin
		pos     = seen_q ? div_res.quotient : held_q;
		err     = $signed({1'b0, target_q}) - $signed({1'b0, pos});
		err_abs = err[ErrWidth-1] ? PosWidth'(-err) : err[PosWidth-1:0];
		k       = seen_q ? band_count(err_abs) : FullSteps;
		offset  = {4'b0000, k} * {3'b000, step_q};
		if (seen_q)
			angle = err[ErrWidth-1] ? $signed({2'b00, neutral_q}) + $signed({3'b000, offset})
			                        : $signed({2'b00, neutral_q}) - $signed({3'b000, offset});
		else
			angle = (held_q < target_q) ? $signed({2'b00, neutral_q}) - $signed({3'b000, offset})
			                            : $signed({2'b00, neutral_q}) + $signed({3'b000, offset});
		if (angle < 0)
			angle_sat = '0;
		else if (angle > 10'sd255)
			angle_sat = '1;
		else
			angle_sat = angle[AngleWidth-1:0];
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (fin_load)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (fin_load) begin
			steering_angle <= angle_sat;
			line_position  <= pos;
			position_error <= err;
			line_seen      <= seen_q;
		end
	end

	assign out_valid = out_valid_q;

	// divider only runs with a nonzero count
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> scan_res.count != '0)
		else $error("divider started with zero divisor");

	// held position stays on the sensor scale
	a_held_range: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= PosMax)
		else $error("held position out of range");

	// after a result load, out_valid is high and the sequencer is back in idle
	a_load_state: assert property (@(posedge clk) disable iff (!arst_n)
		fin_load |=> out_valid_q && state_q == ST_IDLE)
		else $error("result load did not complete");

	// no new word while a word is in progress
	a_one_word: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> in_stall)
		else $error("input accepted while busy");

endmodule

`default_nettype wire
